// ===== hw/rtl/jtc_pkg.sv =====
`default_nettype none
package jtc_pkg;

  // Fixed field widths
  localparam int BLK_W  = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 6;
  localparam int OPEN_W = 7;
  localparam int MAXB_W = 7;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Admission arithmetic: count + (open + 1) * max_blocks
  localparam int NEED_W = 15;

  localparam logic [OPEN_W-1:0] OPEN_LIMIT = 7'd64;
  localparam logic [MAXB_W-1:0] MAXB_RESET = 7'd10;

  // Register map, selected by paddr bit 2
  typedef enum logic {
    REG_MAX_BLOCKS    = 1'b0,
    REG_JOURNAL_START = 1'b1
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_END    = 2'd1,
    KIND_WRITE  = 2'd2,
    KIND_COMMIT = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK            = 3'd0,
    ST_WAIT          = 3'd1,
    ST_FULL          = 3'd2,
    ST_OUTSIDE       = 3'd3,
    ST_END_IN_COMMIT = 3'd4,
    ST_UNEXPECTED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_HIT,
    S_MISS,
    S_LIST
  } state_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  committing;
    logic  open_zero;
    logic  open_one;
    logic  open_max;
    logic  entry_zero;
    logic  entry_full;
    logic  room_ok;
    logic  hit;
    logic  at_end;
    logic  out_free;
  } jtc_stat_t;

  // Controller to datapath
  typedef struct packed {
    logic    take;
    logic    idx_inc;
    logic    out_load;
    status_t status;
    logic    new_entry;
    logic    copy;
    logic    last;
    logic    open_inc;
    logic    open_dec;
    logic    commit_start;
    logic    commit_end;
    logic    append;
  } jtc_cmd_t;

  // Result beat payload
  typedef struct packed {
    status_t             status;
    logic                new_entry;
    logic                copy_valid;
    logic [SLOT_W-1:0]   journal_slot;
    logic [BLK_W-1:0]    journal_address;
    logic [BLK_W-1:0]    home_block;
    logic                last;
    logic [BLK_W-1:0]    commit_count;
    logic                commit_running;
    logic [OPEN_W-1:0]   open_operations;
    logic [OPEN_W-1:0]   logged_count;
  } jtc_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jtc_ifs.sv =====
`default_nettype none
// Input event channel
interface jtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] block_number;

  modport source (output valid, kind, block_number, input ready);
  modport sink   (input valid, kind, block_number, output ready);
endinterface

// Result channel
interface jtc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        new_entry;
  logic        copy_valid;
  logic [5:0]  journal_slot;
  logic [31:0] journal_address;
  logic [31:0] home_block;
  logic        last;
  logic [31:0] commit_count;
  logic        commit_running;
  logic [6:0]  open_operations;
  logic [6:0]  logged_count;

  modport source (output valid, status, new_entry, copy_valid, journal_slot, journal_address,
                  home_block, last, commit_count, commit_running, open_operations,
                  logged_count, input ready);
  modport sink   (input valid, status, new_entry, copy_valid, journal_slot, journal_address,
                  home_block, last, commit_count, commit_running, open_operations,
                  logged_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/journal_transaction_controller.sv =====
// Flow: a single-beat event (begin, end, commit finished, errors) is captured into the held event
// register, then loads the result register from the decode state once that is free; a block write
// walks the table (one table compare a cycle) to a hit or miss state; a commit listing gives one
// copy beat a cycle per logged entry, sink ready. One event at a time: the next is taken again
// from idle only after the last result of the current one is loaded.
// Synchronous active-low reset: counters, commit flag, result valid, sequencer, config defaults.
`default_nettype none
module journal_transaction_controller
  import jtc_pkg::*;
#(
  parameter int LOG_ENTRIES = 30
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  jtc_in_if.sink                 in_if,
  jtc_out_if.source              out_if,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  jtc_cmd_t          cmd;
  jtc_stat_t         stat;
  jtc_res_t          res;
  logic [MAXB_W-1:0] max_blocks;
  logic [BLK_W-1:0]  journal_start;
  logic              in_ready;
  logic              out_valid;

  jtc_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .max_blocks    (max_blocks),
    .journal_start (journal_start)
  );

  jtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jtc_dp #(
    .LOG_ENTRIES (LOG_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_if.kind),
    .in_block_number (in_if.block_number),
    .max_blocks      (max_blocks),
    .journal_start   (journal_start),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_if.ready),
    .res             (res)
  );

  // channel hookup
  assign in_if.ready            = in_ready;
  assign out_if.valid           = out_valid;
  assign out_if.status          = res.status;
  assign out_if.new_entry       = res.new_entry;
  assign out_if.copy_valid      = res.copy_valid;
  assign out_if.journal_slot    = res.journal_slot;
  assign out_if.journal_address = res.journal_address;
  assign out_if.home_block      = res.home_block;
  assign out_if.last            = res.last;
  assign out_if.commit_count    = res.commit_count;
  assign out_if.commit_running  = res.commit_running;
  assign out_if.open_operations = res.open_operations;
  assign out_if.logged_count    = res.logged_count;

  // a commit only runs with every operation closed
  a_commit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    stat.committing |-> stat.open_zero)
    else $error("commit running with open operations");

  // copy beats belong to a running commit
  a_copy_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.copy_valid) |-> (out_if.commit_running && out_if.status == ST_OK))
    else $error("copy beat outside a commit");

  // table never overfills
  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.logged_count <= OPEN_W'(LOG_ENTRIES)))
    else $error("logged count beyond table depth");

  // one event at a time
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second event taken while busy");

endmodule
`default_nettype wire

// ===== hw/rtl/jtc_cfg.sv =====
`default_nettype none
module jtc_cfg
  import jtc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [MAXB_W-1:0] max_blocks,
  output logic      [BLK_W-1:0]  journal_start
);

  logic [MAXB_W-1:0] max_r, max_nxt;
  logic [BLK_W-1:0]  start_r, start_nxt;
  cfg_reg_t          reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[CFG_AW-1]);
  assign wr_en   = psel && penable && pwrite;

  // register write decode
  always_comb begin
    max_nxt   = max_r;
    start_nxt = start_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_BLOCKS:    max_nxt   = pwdata[MAXB_W-1:0];
        REG_JOURNAL_START: start_nxt = pwdata[BLK_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= MAXB_RESET;
      start_r <= '0;
    end else begin
      max_r   <= max_nxt;
      start_r <= start_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_MAX_BLOCKS:    prdata = {{(CFG_DW-MAXB_W){1'b0}}, max_r};
      REG_JOURNAL_START: prdata = start_r;
    endcase
  end

  assign max_blocks    = max_r;
  assign journal_start = start_r;

endmodule
`default_nettype wire

// ===== hw/rtl/jtc_ctrl.sv =====
`default_nettype none
module jtc_ctrl
  import jtc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire jtc_stat_t stat,
  output jtc_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      // decode the held event once the result register is free
      S_EXEC: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
          cmd.last  = 1'b1;
          unique case (stat.kind)
            KIND_BEGIN: begin
              cmd.out_load = 1'b1;
              if (stat.committing || stat.open_max || !stat.room_ok) begin
                cmd.status = ST_WAIT;
              end else begin
                cmd.open_inc = 1'b1;
              end
            end
            KIND_END: begin
              priority if (stat.committing) begin
                cmd.out_load = 1'b1;
                cmd.status   = ST_END_IN_COMMIT;
              end else if (stat.open_zero) begin
                cmd.out_load = 1'b1;
                cmd.status   = ST_UNEXPECTED;
              end else if (!stat.open_one) begin
                cmd.out_load = 1'b1;
                cmd.open_dec = 1'b1;
              end else begin
                // last operation closes: commit starts
                cmd.open_dec     = 1'b1;
                cmd.commit_start = 1'b1;
                if (stat.entry_zero) begin
                  cmd.out_load = 1'b1;
                end else begin
                  cmd.last  = 1'b0;
                  state_nxt = S_LIST;
                end
              end
            end
            KIND_WRITE: begin
              priority if (stat.entry_full) begin
                cmd.out_load = 1'b1;
                cmd.status   = ST_FULL;
              end else if (stat.open_zero) begin
                cmd.out_load = 1'b1;
                cmd.status   = ST_OUTSIDE;
              end else if (stat.entry_zero) begin
                cmd.last  = 1'b0;
                state_nxt = S_MISS;
              end else begin
                cmd.last  = 1'b0;
                state_nxt = S_SRCH;
              end
            end
            KIND_COMMIT: begin
              cmd.out_load = 1'b1;
              if (!stat.committing) begin
                cmd.status = ST_UNEXPECTED;
              end else begin
                cmd.commit_end = 1'b1;
              end
            end
          endcase
        end
      end

      // one table entry compared per cycle
      S_SRCH: begin
        priority if (stat.hit) begin
          state_nxt = S_HIT;
        end else if (stat.at_end) begin
          state_nxt = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end

      S_HIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_MISS: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.last      = 1'b1;
          cmd.new_entry = 1'b1;
          cmd.append    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // one copy beat per logged entry
      S_LIST: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.copy     = 1'b1;
          if (stat.at_end) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/jtc_dp.sv =====
`default_nettype none
module jtc_dp
  import jtc_pkg::*;
#(
  parameter int LOG_ENTRIES = 30
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [BLK_W-1:0]  in_block_number,
  input  wire logic [MAXB_W-1:0] max_blocks,
  input  wire logic [BLK_W-1:0]  journal_start,
  input  wire jtc_cmd_t          cmd,
  output jtc_stat_t              stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jtc_res_t               res
);

  localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int CNT_W = $clog2(LOG_ENTRIES + 1);

  // held event
  kind_t              kind_r;
  logic [BLK_W-1:0]   blk_r;

  // journal state
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [OPEN_W-1:0]  open_r, open_nxt;
  logic               com_r, com_nxt;
  logic [BLK_W-1:0]   done_r, done_nxt;

  // table walk
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [BLK_W-1:0]   rd_data_r;
  logic [BLK_W-1:0]   mem [LOG_ENTRIES];

  // result register
  logic               out_valid_r;
  jtc_res_t           res_r;
  logic [SLOT_W-1:0]  slot;
  logic [NEED_W-1:0]  need;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= kind_t'(in_kind);
      blk_r  <= in_block_number;
    end
  end

  // walk index; the read address runs one ahead on an advance
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign rd_addr = cmd.idx_inc ? (idx_r + IDX_W'(1)) : idx_r;

  // block table
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[cnt_r[IDX_W-1:0]] <= blk_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // state updates
  always_comb begin
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    com_nxt  = com_r;
    done_nxt = done_r;
    if (cmd.append)       cnt_nxt  = cnt_r + CNT_W'(1);
    if (cmd.open_inc)     open_nxt = open_r + OPEN_W'(1);
    if (cmd.open_dec)     open_nxt = open_r - OPEN_W'(1);
    if (cmd.commit_start) com_nxt  = 1'b1;
    if (cmd.commit_end) begin
      cnt_nxt  = '0;
      com_nxt  = 1'b0;
      done_nxt = done_r + BLK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      open_r <= '0;
      com_r  <= 1'b0;
      done_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      open_r <= open_nxt;
      com_r  <= com_nxt;
      done_r <= done_nxt;
    end
  end

  // admission: entries + (open + 1) * worst case must fit
  assign need = NEED_W'(cnt_r)
              + (NEED_W'(open_r) + NEED_W'(1)) * NEED_W'(max_blocks);

  always_comb begin
    stat.kind       = kind_r;
    stat.committing = com_r;
    stat.open_zero  = (open_r == '0);
    stat.open_one   = (open_r == OPEN_W'(1));
    stat.open_max   = (open_r >= OPEN_LIMIT);
    stat.entry_zero = (cnt_r == '0);
    stat.entry_full = (cnt_r >= CNT_W'(LOG_ENTRIES));
    stat.room_ok    = (need <= NEED_W'(LOG_ENTRIES));
    stat.hit        = (rd_data_r == blk_r);
    stat.at_end     = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // result beat
  assign slot = cmd.copy ? SLOT_W'(idx_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r.status          <= cmd.status;
      res_r.new_entry       <= cmd.new_entry;
      res_r.copy_valid      <= cmd.copy;
      res_r.journal_slot    <= slot;
      res_r.journal_address <= cmd.copy ? (journal_start + BLK_W'(slot) + BLK_W'(1)) : '0;
      res_r.home_block      <= cmd.copy ? rd_data_r : '0;
      res_r.last            <= cmd.last;
      res_r.commit_count    <= done_nxt;
      res_r.commit_running  <= com_nxt;
      res_r.open_operations <= open_nxt;
      res_r.logged_count    <= OPEN_W'(cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire
